FILE: sv/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared codes and control types of the best-fit pool allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

  // item function codes
  localparam logic [1:0] FN_INIT    = 2'd0;
  localparam logic [1:0] FN_ALLOC   = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_INIT_BAD  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_POOL  = 2'd1;
  localparam logic [1:0] CFG_ALIGN = 2'd2;

  localparam int unsigned LEN_W  = 32;
  localparam int unsigned ADDR_W = 48;

  // control of one ring of extent cells
  typedef struct packed {
    logic shift;
    logic clr;
    logic seed;
    logic repl;
  } ring_ctl_t;

endpackage

FILE: sv/bfpa_cell.sv
// ----------------------------------------------------------------------------
// bfpa_cell
// One extent slot: valid bit, start offset and length.
// ----------------------------------------------------------------------------
module bfpa_cell #(
  parameter int unsigned SW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ld,
  input  logic          d_valid,
  input  logic [SW-1:0] d_start,
  input  logic [31:0]   d_len,
  output logic          q_valid,
  output logic [SW-1:0] q_start,
  output logic [31:0]   q_len
);

  logic          valid_r;
  logic [SW-1:0] start_r;
  logic [31:0]   len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      start_r <= d_start;
      len_r   <= d_len;
    end
  end

  assign q_valid = valid_r;
  assign q_start = start_r;
  assign q_len   = len_r;

endmodule

FILE: sv/bfpa_ring.sv
// ----------------------------------------------------------------------------
// bfpa_ring
// Circular chain of extent cells; cell 0 is the head seen by the sequencer.
// ----------------------------------------------------------------------------
module bfpa_ring #(
  parameter int unsigned N  = 64,
  parameter int unsigned SW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bfpa_pkg::ring_ctl_t ctl,
  input  logic                w_valid,
  input  logic [SW-1:0]       w_start,
  input  logic [31:0]         w_len,
  output logic                h_valid,
  output logic [SW-1:0]       h_start,
  output logic [31:0]         h_len
);
  import bfpa_pkg::*;

  logic          q_valid [N];
  logic [SW-1:0] q_start [N];
  logic [31:0]   q_len   [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic          n_valid, d_valid;
    logic [SW-1:0] n_start, d_start;
    logic [31:0]   n_len, d_len;

    if (i == N - 1) begin : g_tail
      // head wraps around to the tail, optionally replaced on the way
      assign n_valid = ctl.repl ? w_valid : q_valid[0];
      assign n_start = ctl.repl ? w_start : q_start[0];
      assign n_len   = ctl.repl ? w_len   : q_len[0];
    end else begin : g_mid
      assign n_valid = q_valid[i+1];
      assign n_start = q_start[i+1];
      assign n_len   = q_len[i+1];
    end

    if (i == 0) begin : g_head
      assign d_valid = ctl.clr ? (ctl.seed & w_valid) : n_valid;
    end else begin : g_body
      assign d_valid = ctl.clr ? 1'b0 : n_valid;
    end
    assign d_start = ctl.clr ? w_start : n_start;
    assign d_len   = ctl.clr ? w_len   : n_len;

    bfpa_cell #(.SW(SW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ld      (ctl.shift | ctl.clr),
      .d_valid (d_valid),
      .d_start (d_start),
      .d_len   (d_len),
      .q_valid (q_valid[i]),
      .q_start (q_start[i]),
      .q_len   (q_len[i])
    );
  end

  assign h_valid = q_valid[0];
  assign h_start = q_start[0];
  assign h_len   = q_len[0];

endmodule

FILE: sv/best_fit_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_pool_allocator_core
// Best-fit pool allocator with coalescing, free and used extents in cell rings.
// Init, zero-size and ignored items go from S_IDLE through S_FIN to the output register.
// Allocate: S_DIV for the alignment remainder (skipped when align is zero), then S_SCAN
//   rotates both rings, S_UPD rotates them again to write back, then S_FIN.
// Release: S_USCAN rotates the used ring, S_FSCAN the free ring, S_UPD both, then S_FIN;
//   while the output register stays full, the result waits in S_FIN.
// One item at a time; the next is taken while its result waits in the output.
// Synchronous active-low reset empties both rings and zeroes totals, counts and config registers.
// ----------------------------------------------------------------------------
module best_fit_pool_allocator_core #(
  parameter int unsigned MAX_FREE_EXTENTS = 64,
  parameter int unsigned MAX_USED_EXTENTS = 64,
  parameter int unsigned OFFSET_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_req_size,
  input  logic [47:0] in_req_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [47:0] out_grant_address,
  output logic [31:0] out_grant_size,
  output logic [31:0] out_free_bytes,
  output logic [31:0] out_used_bytes,
  output logic [6:0]  out_free_extents,
  output logic [6:0]  out_used_extents
);
  import bfpa_pkg::*;

  localparam int unsigned OW  = OFFSET_BITS;
  localparam int unsigned FKW = $clog2(MAX_FREE_EXTENTS + 1);
  localparam int unsigned UKW = $clog2(MAX_USED_EXTENTS + 1);
  localparam logic [FKW-1:0] F_N = FKW'(MAX_FREE_EXTENTS);
  localparam logic [UKW-1:0] U_N = UKW'(MAX_USED_EXTENTS);
  localparam logic [48:0] POOL_LIM = 49'(1) << OFFSET_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SCAN, S_USCAN, S_FSCAN, S_UPD, S_FIN
  } state_t;

  state_t state_r;

  logic [47:0] base_r;
  logic [31:0] pool_r, align_r;

  logic [31:0] size_r, rsz_r, rem_r, sh_r;
  logic [47:0] off_r;
  logic [4:0]  dcnt_r;
  logic [FKW-1:0] fk_r, best_r, prev_r, next_r, eslot_r;
  logic [UKW-1:0] uk_r, uslot_r;
  logic bfound_r, ufound_r, pfound_r, nfound_r, efound_r;
  logic [31:0] blen_r, ulen_r, plen_r, nlen_r;
  logic [OW-1:0] bstart_r, pstart_r;

  logic [FKW-1:0] fw_idx_r, fkill_idx_r;
  logic           fw_v_r, fkill_en_r;
  logic [OW-1:0]  fw_s_r;
  logic [31:0]    fw_l_r;
  logic [UKW-1:0] uw_idx_r;
  logic           uw_v_r;
  logic [OW-1:0]  uw_s_r;
  logic [31:0]    uw_l_r;

  logic [31:0]    free_total_r, used_total_r;
  logic [FKW-1:0] fcnt_r;
  logic [UKW-1:0] ucnt_r;
  logic [2:0]     st_r;
  logic [47:0]    ga_r;
  logic [31:0]    gs_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [47:0] out_ga_r;
  logic [31:0] out_gs_r, out_fb_r, out_ub_r;
  logic [6:0]  out_fe_r, out_ue_r;

  // ring heads
  logic          fh_valid, uh_valid;
  logic [OW-1:0] fh_start, uh_start;
  logic [31:0]   fh_len, uh_len;
  ring_ctl_t     f_ctl, u_ctl;
  logic          f_wv, u_wv;
  logic [OW-1:0] f_ws, u_ws;
  logic [31:0]   f_wl, u_wl;

  logic        in_acc, init_bad, init_go;
  logic [32:0] rem_sh;
  logic [31:0] rem_step;
  logic [32:0] rnd;
  logic [48:0] rel_end;
  logic        f_busy, u_busy;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign init_bad  = (base_r == 48'd0) || (pool_r == 32'd0) || (49'(pool_r) > POOL_LIM);
  assign init_go   = in_acc && (in_func == FN_INIT) && !init_bad;
  assign f_busy    = fk_r != F_N;
  assign u_busy    = uk_r != U_N;

  // restoring remainder step, one dividend bit a cycle
  assign rem_sh   = {rem_r, sh_r[31]};
  assign rem_step = (rem_sh >= {1'b0, align_r}) ? 32'(rem_sh - {1'b0, align_r})
                                                : rem_sh[31:0];
  assign rnd      = {1'b0, size_r} - {1'b0, rem_step}
                    + ((rem_step != 32'd0) ? {1'b0, align_r} : 33'd0);
  assign rel_end  = 49'(off_r) + 49'(ulen_r);

  always_comb begin
    f_ctl = '0;
    f_wv  = fw_v_r;
    f_ws  = fw_s_r;
    f_wl  = fw_l_r;
    u_ctl = '0;
    u_wv  = uw_v_r;
    u_ws  = uw_s_r;
    u_wl  = uw_l_r;
    if (init_go) begin
      f_ctl.clr  = 1'b1;
      f_ctl.seed = 1'b1;
      f_wv       = 1'b1;
      f_ws       = '0;
      f_wl       = pool_r;
      u_ctl.clr  = 1'b1;
    end
    if ((state_r == S_SCAN || state_r == S_FSCAN || state_r == S_UPD) && f_busy) begin
      f_ctl.shift = 1'b1;
    end
    if ((state_r == S_SCAN || state_r == S_USCAN || state_r == S_UPD) && u_busy) begin
      u_ctl.shift = 1'b1;
    end
    if (state_r == S_UPD && f_busy) begin
      if (fk_r == fw_idx_r) begin
        f_ctl.repl = 1'b1;
      end else if (fkill_en_r && fk_r == fkill_idx_r) begin
        f_ctl.repl = 1'b1;
        f_wv       = 1'b0;
      end
    end
    if (state_r == S_UPD && u_busy && uk_r == uw_idx_r) begin
      u_ctl.repl = 1'b1;
    end
  end

  bfpa_ring #(.N(MAX_FREE_EXTENTS), .SW(OW)) u_free_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (f_ctl),
    .w_valid (f_wv),
    .w_start (f_ws),
    .w_len   (f_wl),
    .h_valid (fh_valid),
    .h_start (fh_start),
    .h_len   (fh_len)
  );

  bfpa_ring #(.N(MAX_USED_EXTENTS), .SW(OW)) u_used_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (u_ctl),
    .w_valid (u_wv),
    .w_start (u_ws),
    .w_len   (u_wl),
    .h_valid (uh_valid),
    .h_start (uh_start),
    .h_len   (uh_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= '0;
      pool_r       <= '0;
      align_r      <= '0;
      free_total_r <= '0;
      used_total_r <= '0;
      fcnt_r       <= '0;
      ucnt_r       <= '0;
      fk_r         <= '0;
      uk_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BASE:  base_r  <= cfg_data;
          CFG_POOL:  pool_r  <= cfg_data[31:0];
          CFG_ALIGN: align_r <= cfg_data[31:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      if (f_ctl.shift) fk_r <= fk_r + 1'b1;
      if (u_ctl.shift) uk_r <= uk_r + 1'b1;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            size_r   <= in_req_size;
            ga_r     <= '0;
            gs_r     <= '0;
            fk_r     <= '0;
            uk_r     <= '0;
            bfound_r <= 1'b0;
            ufound_r <= 1'b0;
            priority case (in_func)
              FN_INIT: begin
                state_r <= S_FIN;
                if (init_bad) begin
                  st_r <= ST_INIT_BAD;
                end else begin
                  st_r         <= ST_OK;
                  free_total_r <= pool_r;
                  used_total_r <= '0;
                  fcnt_r       <= FKW'(1);
                  ucnt_r       <= '0;
                end
              end
              FN_ALLOC: begin
                if (in_req_size == 32'd0) begin
                  st_r    <= ST_ZERO_SIZE;
                  state_r <= S_FIN;
                end else if (align_r == 32'd0) begin
                  st_r    <= ST_OK;
                  rsz_r   <= in_req_size;
                  state_r <= S_SCAN;
                end else begin
                  st_r    <= ST_OK;
                  rem_r   <= '0;
                  sh_r    <= in_req_size;
                  dcnt_r  <= '0;
                  state_r <= S_DIV;
                end
              end
              FN_RELEASE: begin
                st_r <= ST_OK;
                if (in_req_address != 48'd0) begin
                  off_r   <= in_req_address - base_r;
                  state_r <= S_USCAN;
                end else begin
                  state_r <= S_FIN;
                end
              end
              default: begin
                st_r    <= ST_OK;
                state_r <= S_FIN;
              end
            endcase
          end
        end

        S_DIV: begin
          rem_r  <= rem_step;
          sh_r   <= {sh_r[30:0], 1'b0};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 5'd31) begin
            if (rnd[32]) begin
              st_r    <= ST_NO_FIT;
              state_r <= S_FIN;
            end else begin
              rsz_r   <= rnd[31:0];
              state_r <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (f_busy) begin
            if (fh_valid && fh_len >= rsz_r &&
                (!bfound_r || fh_len < blen_r ||
                 (fh_len == blen_r && fh_start < bstart_r))) begin
              bfound_r <= 1'b1;
              best_r   <= fk_r;
              blen_r   <= fh_len;
              bstart_r <= fh_start;
            end
          end
          if (u_busy && !ufound_r && !uh_valid) begin
            ufound_r <= 1'b1;
            uslot_r  <= uk_r;
          end
          if (!f_busy && !u_busy) begin
            fk_r <= '0;
            uk_r <= '0;
            if (!bfound_r) begin
              st_r    <= ST_NO_FIT;
              state_r <= S_FIN;
            end else if (!ufound_r) begin
              st_r    <= ST_FULL;
              state_r <= S_FIN;
            end else begin
              ga_r         <= base_r + 48'(bstart_r);
              gs_r         <= rsz_r;
              fw_idx_r     <= best_r;
              fw_v_r       <= (blen_r != rsz_r);
              fw_s_r       <= OW'(bstart_r + OW'(rsz_r));
              fw_l_r       <= blen_r - rsz_r;
              fkill_en_r   <= 1'b0;
              fkill_idx_r  <= best_r;
              uw_idx_r     <= uslot_r;
              uw_v_r       <= 1'b1;
              uw_s_r       <= bstart_r;
              uw_l_r       <= rsz_r;
              free_total_r <= free_total_r - rsz_r;
              used_total_r <= used_total_r + rsz_r;
              ucnt_r       <= ucnt_r + 1'b1;
              if (blen_r == rsz_r) fcnt_r <= fcnt_r - 1'b1;
              state_r      <= S_UPD;
            end
          end
        end

        S_USCAN: begin
          if (u_busy) begin
            if (!ufound_r && uh_valid && 48'(uh_start) == off_r) begin
              ufound_r <= 1'b1;
              uslot_r  <= uk_r;
              ulen_r   <= uh_len;
            end
          end else begin
            uk_r     <= '0;
            fk_r     <= '0;
            pfound_r <= 1'b0;
            nfound_r <= 1'b0;
            efound_r <= 1'b0;
            if (!ufound_r) begin
              st_r    <= ST_NOT_ALLOC;
              state_r <= S_FIN;
            end else begin
              state_r <= S_FSCAN;
            end
          end
        end

        S_FSCAN: begin
          if (f_busy) begin
            if (fh_valid) begin
              if (!pfound_r && 49'(fh_start) + 49'(fh_len) == 49'(off_r)) begin
                pfound_r <= 1'b1;
                prev_r   <= fk_r;
                plen_r   <= fh_len;
                pstart_r <= fh_start;
              end
              if (!nfound_r && 49'(fh_start) == rel_end) begin
                nfound_r <= 1'b1;
                next_r   <= fk_r;
                nlen_r   <= fh_len;
              end
            end else if (!efound_r) begin
              efound_r <= 1'b1;
              eslot_r  <= fk_r;
            end
          end else begin
            fk_r <= '0;
            uk_r <= '0;
            if (!pfound_r && !nfound_r && !efound_r) begin
              st_r    <= ST_FULL;
              state_r <= S_FIN;
            end else begin
              fw_idx_r     <= pfound_r ? prev_r : (nfound_r ? next_r : eslot_r);
              fw_v_r       <= 1'b1;
              fw_s_r       <= pfound_r ? pstart_r : off_r[OW-1:0];
              fw_l_r       <= ulen_r + (pfound_r ? plen_r : 32'd0)
                                     + (nfound_r ? nlen_r : 32'd0);
              // both neighbors: merged extent lands on prev, next goes away
              fkill_en_r   <= pfound_r && nfound_r;
              fkill_idx_r  <= next_r;
              uw_idx_r     <= uslot_r;
              uw_v_r       <= 1'b0;
              uw_s_r       <= '0;
              uw_l_r       <= '0;
              used_total_r <= used_total_r - ulen_r;
              free_total_r <= free_total_r + ulen_r;
              ucnt_r       <= ucnt_r - 1'b1;
              if (!pfound_r && !nfound_r) fcnt_r <= fcnt_r + 1'b1;
              else if (pfound_r && nfound_r) fcnt_r <= fcnt_r - 1'b1;
              state_r      <= S_UPD;
            end
          end
        end

        S_UPD: begin
          if (!f_busy && !u_busy) begin
            fk_r    <= '0;
            uk_r    <= '0;
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_ga_r     <= ga_r;
            out_gs_r     <= gs_r;
            out_fb_r     <= free_total_r;
            out_ub_r     <= used_total_r;
            out_fe_r     <= 7'(fcnt_r);
            out_ue_r     <= 7'(ucnt_r);
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_grant_address = out_ga_r;
  assign out_grant_size    = out_gs_r;
  assign out_free_bytes    = out_fb_r;
  assign out_used_bytes    = out_ub_r;
  assign out_free_extents  = out_fe_r;
  assign out_used_extents  = out_ue_r;

endmodule

FILE: sv/bfpa_chk.sv
// ----------------------------------------------------------------------------
// bfpa_chk
// Port-level checks of the best-fit pool allocator.
// ----------------------------------------------------------------------------
module bfpa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [47:0] out_grant_address,
  input logic [31:0] out_grant_size
);
  import bfpa_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_grant_address))
    else $error("result changed while stalled");

  // a failed item grants nothing
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_grant_address == 48'd0
      && out_grant_size == 32'd0)
    else $error("grant on a failed item");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_INIT_BAD)
    else $error("undefined status code");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // one item in flight: no new item accepted in the cycle after acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind best_fit_pool_allocator_core bfpa_chk u_bfpa_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_grant_address (out_grant_address),
  .out_grant_size    (out_grant_size)
);
